// File: src/kmer_repeat_low_entropy_detector_core_defines.svh
// assertion macros shared by the detector modules
`ifndef KMER_REPEAT_LOW_ENTROPY_DETECTOR_CORE_DEFINES_SVH
`define KMER_REPEAT_LOW_ENTROPY_DETECTOR_CORE_DEFINES_SVH

// condition must never hold outside reset
`define KMRD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// consequence must hold in the same cycle
`define KMRD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the next cycle
`define KMRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/kmrd_pkg.sv
// shared constants and types of the low-entropy read detector
package kmrd_pkg;

  localparam int KMER_LEN     = 3;
  localparam int MAX_READ_LEN = 1024;

  localparam int FIELD_W     = 11;
  localparam int FRAC_W      = 9;
  localparam int FRAC_RESET  = 77;
  localparam int POS_W       = $clog2(MAX_READ_LEN + 1);
  localparam int KMER_W      = 2 * KMER_LEN;
  localparam int TABLE_DEPTH = 1 << KMER_W;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_BASE   = 1'b1;

  // one queued work item: a header carries thresholds, a base carries its k-mer
  typedef struct packed {
    logic              is_header;
    logic              last;
    logic [KMER_W-1:0] kmer;
    logic [POS_W-1:0]  pos;
    logic              countable;
    logic              in_seg1;
    logic              in_seg2;
    logic [POS_W-1:0]  thr_total;
    logic [POS_W-1:0]  thr_seg1;
    logic [POS_W-1:0]  thr_seg2;
  } entry_t;

endpackage

// File: src/kmrd_thr_lane.sv
// three-stage threshold pipeline: round(len * frac / (256 * k)), saturated
module kmrd_thr_lane
  import kmrd_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [FIELD_W-1:0] len,
  input  logic               disabled,
  input  logic [FRAC_W-1:0]  frac,
  output logic [POS_W-1:0]   thr
);

  localparam int PROD_W    = FIELD_W + FRAC_W;
  localparam int NUM_W     = PROD_W + 2;
  localparam int DEN_SHIFT = 9;  // 2*len*frac over 512*k
  localparam int X_W       = NUM_W - DEN_SHIFT;
  localparam int RS        = X_W;
  localparam int RECIP     = (1 << RS) / KMER_LEN;
  localparam int RECIP_W   = RS + 1;
  localparam int MUL_W     = X_W + RECIP_W;
  localparam int QK_W      = X_W + 4;
  localparam int HALF      = 256 * KMER_LEN;

  logic [PROD_W-1:0] prod;
  logic              dis1;
  logic [X_W-1:0]    x_r;
  logic [MUL_W-1:0]  m_r;
  logic              dis2;

  logic [NUM_W-1:0] num;
  logic [X_W-1:0]   x;
  logic [X_W-1:0]   q_est;
  logic [QK_W-1:0]  qk;
  logic [QK_W-1:0]  rem;
  logic [X_W-1:0]   q;
  logic [POS_W-1:0] thr_c;

  always_comb begin
    num   = (NUM_W'(prod) << 1) + NUM_W'(HALF);
    x     = X_W'(num >> DEN_SHIFT);
    // reciprocal estimate is low by at most one
    q_est = X_W'(m_r >> RS);
    qk    = QK_W'(q_est) * QK_W'(KMER_LEN);
    rem   = QK_W'(x_r) - qk;
    q     = q_est + X_W'(rem >= QK_W'(KMER_LEN));
    if (dis2 || (q > X_W'(MAX_READ_LEN))) begin
      thr_c = POS_W'(MAX_READ_LEN);
    end else begin
      thr_c = POS_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(len) * PROD_W'(frac);
      dis1 <= disabled;
    end
    x_r  <= x;
    m_r  <= MUL_W'(x) * MUL_W'(RECIP);
    dis2 <= dis1;
    thr  <= thr_c;
  end

endmodule

// File: src/kmrd_front.sv
// front end: takes items, tracks the k-mer window, builds queue entries
module kmrd_front
  import kmrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [FRAC_W-1:0]     cfg_data,
  input  logic                  fifo_full,
  output logic                  push,
  output entry_t                push_entry
);

  localparam int OFF_BASE = 0;
  localparam int OFF_LEN  = OFF_BASE + 2;
  localparam int OFF_S1S  = OFF_LEN + FIELD_W;
  localparam int OFF_S1E  = OFF_S1S + FIELD_W;
  localparam int OFF_S2S  = OFF_S1E + FIELD_W;
  localparam int OFF_S2E  = OFF_S2S + FIELD_W;
  localparam int CMP_W    = FIELD_W + 1;

  typedef enum logic [1:0] {ST_RUN, ST_WAIT1, ST_WAIT2, ST_PUSH} state_t;

  state_t             state;
  logic [FRAC_W-1:0]  frac;
  logic [KMER_W-1:0]  window;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   len;
  logic [FIELD_W-1:0] seg1_start, seg1_end, seg2_start, seg2_end;

  logic               hdr_acc, base_acc;
  logic [1:0]         base_in;
  logic [FIELD_W-1:0] rlen, s1s, s1e, s2s, s2e;
  logic [POS_W-1:0]   len_clamp;
  logic [POS_W-1:0]   thr_total, thr_seg1, thr_seg2;
  logic [KMER_W-1:0]  window_next;
  logic [POS_W:0]     pos_inc;
  logic [POS_W-1:0]   p;
  logic [CMP_W-1:0]   p_ext;
  entry_t             base_entry, hdr_entry;

  assign base_in = s_axis_tdata[OFF_BASE +: 2];
  assign rlen    = s_axis_tdata[OFF_LEN +: FIELD_W];
  assign s1s     = s_axis_tdata[OFF_S1S +: FIELD_W];
  assign s1e     = s_axis_tdata[OFF_S1E +: FIELD_W];
  assign s2s     = s_axis_tdata[OFF_S2S +: FIELD_W];
  assign s2e     = s_axis_tdata[OFF_S2E +: FIELD_W];

  assign s_axis_tready = (state == ST_RUN) && !fifo_full;
  assign cfg_ready     = 1'b1;
  assign hdr_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_HEADER);
  assign base_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_BASE);

  assign len_clamp = (rlen > FIELD_W'(MAX_READ_LEN)) ? POS_W'(MAX_READ_LEN) : POS_W'(rlen);

  kmrd_thr_lane u_thr_total (
    .clk(clk), .load(hdr_acc), .len(FIELD_W'(len_clamp)), .disabled(1'b0),
    .frac(frac), .thr(thr_total)
  );

  kmrd_thr_lane u_thr_seg1 (
    .clk(clk), .load(hdr_acc), .len(s1e - s1s), .disabled(s1e < s1s),
    .frac(frac), .thr(thr_seg1)
  );

  kmrd_thr_lane u_thr_seg2 (
    .clk(clk), .load(hdr_acc), .len(s2e - s2s), .disabled(s2e < s2s),
    .frac(frac), .thr(thr_seg2)
  );

  always_comb begin
    window_next = KMER_W'({window, base_in});
    pos_inc     = (POS_W + 1)'(pos) + (POS_W + 1)'(1);
    // k-mer start, meaningful only when countable
    p           = POS_W'(pos_inc - (POS_W + 1)'(KMER_LEN));
    p_ext       = CMP_W'(p);

    base_entry           = '0;
    base_entry.is_header = 1'b0;
    base_entry.last      = s_axis_tlast;
    base_entry.kmer      = window_next;
    base_entry.pos       = p;
    base_entry.countable = (pos_inc >= (POS_W + 1)'(KMER_LEN)) &&
                           (pos_inc < (POS_W + 1)'(len));
    base_entry.in_seg1   = (p_ext + CMP_W'(1) >= CMP_W'(seg1_start)) &&
                           (p_ext < CMP_W'(seg1_end));
    base_entry.in_seg2   = (p_ext + CMP_W'(1) >= CMP_W'(seg2_start)) &&
                           (p_ext < CMP_W'(seg2_end));

    hdr_entry            = '0;
    hdr_entry.is_header  = 1'b1;
    hdr_entry.thr_total  = thr_total;
    hdr_entry.thr_seg1   = thr_seg1;
    hdr_entry.thr_seg2   = thr_seg2;

    if (state == ST_PUSH) begin
      push       = !fifo_full;
      push_entry = hdr_entry;
    end else begin
      push       = base_acc;
      push_entry = base_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      frac       <= FRAC_W'(FRAC_RESET);
      window     <= '0;
      pos        <= '0;
      len        <= '0;
      seg1_start <= '0;
      seg1_end   <= '0;
      seg2_start <= '0;
      seg2_end   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frac <= cfg_data;
      end
      case (state)
        ST_RUN: begin
          if (hdr_acc) begin
            state      <= ST_WAIT1;
            window     <= '0;
            pos        <= '0;
            len        <= len_clamp;
            seg1_start <= s1s;
            seg1_end   <= s1e;
            seg2_start <= s2s;
            seg2_end   <= s2e;
          end else if (base_acc) begin
            window <= window_next;
            if (pos < POS_W'(MAX_READ_LEN)) begin
              pos <= POS_W'(pos_inc);
            end
          end
        end
        ST_WAIT1: state <= ST_WAIT2;
        ST_WAIT2: state <= ST_PUSH;
        ST_PUSH: begin
          if (!fifo_full) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

// File: src/kmrd_fifo.sv
// short queue between the front and back ends
`include "kmer_repeat_low_entropy_detector_core_defines.svh"

module kmrd_fifo
  import kmrd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   not_empty
);

  entry_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full      = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (FIFO_AW + 1)'(1);
        2'b01:   count <= count - (FIFO_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  `KMRD_ASSERT_NEVER(a_fifo_overflow, push && full, "transfer into a full queue")
  `KMRD_ASSERT_NEVER(a_fifo_underflow, pop && !not_empty, "pop from an empty queue")

endmodule

// File: src/kmrd_back.sv
// back end: per-k-mer table read-modify-write, thresholds and sticky flag
`include "kmer_repeat_low_entropy_detector_core_defines.svh"

module kmrd_back
  import kmrd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  entry_t entry,
  input  logic   entry_valid,
  output logic   pop,
  output logic   res_valid,
  input  logic   res_ready,
  output logic   res_flag
);

  typedef struct packed {
    logic [POS_W-1:0] next_pos;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] seg1;
    logic [POS_W-1:0] seg2;
  } row_t;

  row_t                   table_mem [TABLE_DEPTH];
  row_t                   rd_row;
  logic [TABLE_DEPTH-1:0] row_valid;

  logic              s1_valid;
  entry_t            s1;
  logic              fwd_valid;
  logic [KMER_W-1:0] fwd_addr;
  row_t              fwd_row;
  logic [POS_W-1:0]  thr_total, thr_seg1, thr_seg2;
  logic              flagged;

  logic stall, adv, s1_base, counted, hit, wr_en, flagged_next, hdr_now;
  row_t cur_row, new_row;

  always_comb begin
    s1_base = s1_valid && !s1.is_header;
    hdr_now = s1_valid && s1.is_header;
    stall   = s1_base && s1.last && res_valid && !res_ready;
    adv     = !stall;
    pop     = adv && entry_valid;

    // the row written on the edge of this entry's read is not yet in the memory
    if (fwd_valid && (fwd_addr == s1.kmer)) begin
      cur_row = fwd_row;
    end else if (row_valid[s1.kmer]) begin
      cur_row = rd_row;
    end else begin
      cur_row = '0;
    end

    counted = s1_base && s1.countable && (cur_row.next_pos <= s1.pos);
    new_row.next_pos = s1.pos + POS_W'(KMER_LEN);
    new_row.total    = cur_row.total + POS_W'(1);
    new_row.seg1     = cur_row.seg1 + POS_W'(s1.in_seg1);
    new_row.seg2     = cur_row.seg2 + POS_W'(s1.in_seg2);
    hit = (new_row.total >= thr_total) || (new_row.seg1 >= thr_seg1) ||
          (new_row.seg2 >= thr_seg2);
    wr_en = adv && counted;

    if (s1_valid && s1.is_header) begin
      flagged_next = 1'b0;
    end else if (counted && hit) begin
      flagged_next = 1'b1;
    end else begin
      flagged_next = flagged;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[s1.kmer] <= new_row;
    end
    if (pop) begin
      rd_row <= table_mem[entry.kmer];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= entry;
      fwd_addr <= s1.kmer;
      fwd_row  <= new_row;
    end
    if (adv && s1_base && s1.last) begin
      res_flag <= flagged_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      row_valid <= '0;
      thr_total <= '0;
      thr_seg1  <= '0;
      thr_seg2  <= '0;
      flagged   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid  <= pop;
        fwd_valid <= wr_en;
        flagged   <= flagged_next;
        if (s1_valid && s1.is_header) begin
          row_valid <= '0;
          thr_total <= s1.thr_total;
          thr_seg1  <= s1.thr_seg1;
          thr_seg2  <= s1.thr_seg2;
        end else if (wr_en) begin
          row_valid[s1.kmer] <= 1'b1;
        end
      end
      if (adv && s1_base && s1.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `KMRD_ASSERT_NEXT(a_hdr_clears_flag, adv && hdr_now, !flagged, "flag kept over a header")
  `KMRD_ASSERT_NEXT(a_flag_sticky, flagged && !hdr_now, flagged, "sticky flag dropped")

endmodule

// File: src/kmer_repeat_low_entropy_detector_core.sv
// top level of the k-mer repeat low-entropy read detector
// A header item (tuser = 0) opens a read: the front end computes the whole-read
// and two segment thresholds in a three-stage pipeline, holding off the input
// through its WAIT1 and WAIT2 states until they are queued (longer while the
// queue is full); the back end clears its 64-row k-mer table by resetting its
// per-row valid bits. Base items (tuser = 1) are then taken one per cycle while
// the queue has room: the front end builds the k-mer and its start position, the
// back end reads the table for each base and writes each counted row back over a
// registered read/update pipeline, forwarding when the same k-mer repeats. A
// read's flag is offered once its last base (tlast) has passed the queue and the
// back end; a waiting result does not stop the input while the queue has room.
module kmer_repeat_low_entropy_detector_core
  import kmrd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // base_code, read_length, seg1_start, seg1_end, seg2_start, seg2_end, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // repeat_flag, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [FRAC_W-1:0]      cfg_data
);

  logic   fifo_full, fifo_push, fifo_pop, fifo_not_empty, res_flag;
  entry_t push_entry, pop_entry;

  kmrd_front u_front (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .fifo_full(fifo_full),
    .push(fifo_push),
    .push_entry(push_entry)
  );

  kmrd_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(fifo_push),
    .push_entry(push_entry),
    .full(fifo_full),
    .pop(fifo_pop),
    .pop_entry(pop_entry),
    .not_empty(fifo_not_empty)
  );

  kmrd_back u_back (
    .clk(clk),
    .rst(rst),
    .entry(pop_entry),
    .entry_valid(fifo_not_empty),
    .pop(fifo_pop),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res_flag(res_flag)
  );

  assign m_axis_tdata = OUT_TDATA_W'(res_flag);

endmodule

// File: sim/testbench.sv
// testbench for the k-mer repeat low-entropy read detector
`timescale 1ns / 1ps

module testbench;
  import kmrd_pkg::*;

  typedef enum logic [1:0] {BASE_A, BASE_C, BASE_G, BASE_T} base_t;

  typedef struct {
    logic        cmd;
    base_t       base;
    logic        last;
    logic [10:0] len;
    logic [10:0] s1_start;
    logic [10:0] s1_end;
    logic [10:0] s2_start;
    logic [10:0] s2_end;
    int          want;    // typed-in flag, or -1 to take the tracker's
  } stim_t;

  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 220;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic                   s_user = 1'b0;
  logic                   s_last = 1'b0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [FRAC_W-1:0]      cfg_data = '0;

  always #1 clk = ~clk;

  kmer_repeat_low_entropy_detector_core uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // read tracker: thresholds, k-mer tables and the sticky flag
  int unsigned frac_q8 = FRAC_RESET;
  logic [KMER_W-1:0] window = '0;
  int unsigned base_pos = 0;
  int unsigned read_len = 0;
  int unsigned thr_total = 0;
  int unsigned thr_seg1 = 0;
  int unsigned thr_seg2 = 0;
  int unsigned bounds [4] = '{default: 0};
  int unsigned total_cnt [TABLE_DEPTH] = '{default: 0};
  int unsigned seg1_cnt [TABLE_DEPTH] = '{default: 0};
  int unsigned seg2_cnt [TABLE_DEPTH] = '{default: 0};
  int unsigned next_free [TABLE_DEPTH] = '{default: 0};
  bit read_flag = 1'b0;

  bit pending_flags [$];
  int errors = 0;
  int items_sent = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold = 0;
  stim_t plan [$];

  function automatic int unsigned repeat_threshold(input int unsigned len);
    int unsigned thr;
    thr = (2 * len * frac_q8 + 256 * KMER_LEN) / (512 * KMER_LEN);
    return (thr > MAX_READ_LEN) ? MAX_READ_LEN : thr;
  endfunction

  function automatic int unsigned segment_threshold(input int unsigned first,
                                                    input int unsigned stop);
    if (stop < first) return MAX_READ_LEN;
    return repeat_threshold(stop - first);
  endfunction

  // advance the tracker by one accepted item, queue the flag on a last base
  task automatic score_item(input stim_t it);
    int unsigned p;
    int unsigned k;
    if (it.cmd == CMD_HEADER) begin
      total_cnt = '{default: 0};
      seg1_cnt  = '{default: 0};
      seg2_cnt  = '{default: 0};
      next_free = '{default: 0};
      read_len  = (it.len > MAX_READ_LEN) ? MAX_READ_LEN : it.len;
      bounds    = '{it.s1_start, it.s1_end, it.s2_start, it.s2_end};
      thr_total = repeat_threshold(read_len);
      thr_seg1  = segment_threshold(bounds[0], bounds[1]);
      thr_seg2  = segment_threshold(bounds[2], bounds[3]);
      window    = '0;
      base_pos  = 0;
      read_flag = 1'b0;
    end else begin
      window = {window[KMER_W-3:0], it.base};
      if (base_pos + 1 >= KMER_LEN && base_pos + 1 < read_len) begin
        p = base_pos + 1 - KMER_LEN;
        k = 32'(window);
        // a copy overlapping an earlier counted one is skipped
        if (next_free[k] <= p) begin
          next_free[k] = p + KMER_LEN;
          total_cnt[k]++;
          if (p + 1 >= bounds[0] && p < bounds[1]) seg1_cnt[k]++;
          if (p + 1 >= bounds[2] && p < bounds[3]) seg2_cnt[k]++;
          if (total_cnt[k] >= thr_total || seg1_cnt[k] >= thr_seg1 ||
              seg2_cnt[k] >= thr_seg2)
            read_flag = 1'b1;
        end
      end
      if (base_pos < MAX_READ_LEN) base_pos++;
      if (it.last) pending_flags.push_back((it.want >= 0) ? it.want[0] : read_flag);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s, got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send(input stim_t it);
    if (!tx_steady && $urandom_range(0, 2) == 0) begin
      s_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= it.cmd;
    s_last  <= it.last;
    s_data  <= {7'b0, it.s2_end, it.s2_start, it.s1_end, it.s1_start, it.len, it.base};
    do @(posedge clk); while (!s_ready);
    items_sent++;
    score_item(it);
  endtask

  // sender holds off until every flag is back and the pipeline has emptied
  task automatic drain();
    s_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fraction(input int unsigned v);
    cfg_valid <= 1'b1;
    cfg_data  <= v[FRAC_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frac_q8 = v;
  endtask

  function automatic stim_t row(input logic cmd, input base_t base, input logic last,
                                input int len, input int a, input int b, input int c,
                                input int d, input int want);
    stim_t it;
    it = '{cmd, base, last, len[10:0], a[10:0], b[10:0], c[10:0], d[10:0], want};
    return it;
  endfunction

  task automatic random_read(input int unsigned room);
    stim_t it;
    int unsigned len;
    int unsigned n;
    int unsigned r;
    int unsigned motif_len;
    int unsigned m;
    int unsigned a;
    base_t motif [6];
    bit noisy;
    bit close_it;
    r = $urandom_range(0, 99);
    if (r < 80) len = $urandom_range(0, 40);
    else if (r < 93) len = $urandom_range(41, 200);
    else if (r < 97) len = $urandom_range(900, 1024);
    else len = $urandom_range(1025, 2047);
    it.cmd  = CMD_HEADER;
    it.base = base_t'($urandom_range(0, 3));
    it.last = ($urandom_range(0, 9) == 0);
    it.len  = 11'(len);
    it.want = -1;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      a = $urandom_range(0, len);
      it.s1_start = 11'(a);
      it.s1_end   = 11'($urandom_range(a, len));
      a = $urandom_range(0, len);
      it.s2_start = 11'(a);
      it.s2_end   = 11'($urandom_range(a, len));
    end else if (r < 80) begin
      // segment with its end before its start is switched off
      it.s1_start = 11'($urandom_range(1, 2047));
      it.s1_end   = 11'($urandom_range(0, it.s1_start - 1));
      it.s2_start = 11'($urandom_range(0, len));
      it.s2_end   = 11'(len);
    end else if (r < 90) begin
      it.s1_start = 11'($urandom_range(0, 2047));
      it.s1_end   = 11'($urandom_range(0, 2047));
      it.s2_start = 11'($urandom_range(0, 2047));
      it.s2_end   = 11'($urandom_range(0, 2047));
    end else begin
      it.s1_start = '0;
      it.s1_end   = 11'(len);
      it.s2_start = '0;
      it.s2_end   = 11'(len);
    end
    send(it);
    if ($urandom_range(0, 29) == 0) return;

    n = (len > MAX_READ_LEN) ? MAX_READ_LEN : len;
    r = $urandom_range(0, 99);
    if (r < 8) n += $urandom_range(1, 5);
    else if (r < 16 && n > 1) n = $urandom_range(1, n);
    if (n == 0) n = $urandom_range(1, 3);
    // keep the run near its item budget, the header already counts
    if (n + 1 > room) n = (room > 1) ? room - 1 : 1;
    close_it  = ($urandom_range(0, 19) != 0);
    noisy     = ($urandom_range(0, 2) == 0);
    motif_len = $urandom_range(1, 6);
    for (m = 0; m < 6; m++) motif[m] = base_t'($urandom_range(0, 3));
    for (m = 0; m < n; m++) begin
      it.cmd  = CMD_BASE;
      it.base = (noisy || $urandom_range(0, 15) == 0) ? base_t'($urandom_range(0, 3))
                                                      : motif[m % motif_len];
      it.last = close_it && (m == n - 1);
      // header fields are don't-care on a base
      it.len      = 11'($urandom_range(0, 2047));
      it.s1_start = 11'($urandom_range(0, 2047));
      it.s1_end   = 11'($urandom_range(0, 2047));
      it.s2_start = 11'($urandom_range(0, 2047));
      it.s2_end   = 11'($urandom_range(0, 2047));
      send(it);
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_hold <= gap_len();
    end
    if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
  end

  always @(posedge clk) begin
    if (!rst && m_valid && m_ready) begin
      if (pending_flags.size() == 0)
        report_mismatch("flag with no read closed", m_data[0], -1);
      else if (m_data[0] !== pending_flags[0])
        report_mismatch("repeat flag", m_data[0], pending_flags.pop_front());
      else
        void'(pending_flags.pop_front());
    end
  end

  initial begin
    int ph;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // base before any header: zero length, nothing counted
    plan.push_back(row(CMD_BASE, BASE_G, 1, 0, 0, 0, 0, 0, 0));
    // all-ones header, clamped length, empty segments give zero thresholds
    plan.push_back(row(CMD_HEADER, BASE_T, 1, 2047, 2047, 2047, 2047, 2047, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 1, 0, 0, 0, 0, 0, 1));
    // read no longer than a k-mer never flags
    plan.push_back(row(CMD_HEADER, BASE_A, 0, 3, 0, 3, 1, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_A, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_C, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_G, 1, 0, 0, 0, 0, 0, 0));
    // short read, zero whole-read threshold
    plan.push_back(row(CMD_HEADER, BASE_A, 0, 4, 0, 4, 0, 4, -1));
    plan.push_back(row(CMD_BASE, BASE_C, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_A, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_G, 1, 0, 0, 0, 0, 0, 1));
    plan.push_back(row(CMD_HEADER, BASE_A, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_A, 1, 0, 0, 0, 0, 0, 0));
    // repeat inside a read with one segment switched off
    plan.push_back(row(CMD_HEADER, BASE_A, 0, 9, 5, 2, 1, 9, -1));
    plan.push_back(row(CMD_BASE, BASE_G, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_A, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_A, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_A, 0, 0, 0, 0, 0, 0, -1));
    plan.push_back(row(CMD_BASE, BASE_T, 1, 0, 0, 0, 0, 0, -1));
    foreach (plan[i]) send(plan[i]);
    drain();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_fraction(256);
        1: write_fraction(0);
        4: write_fraction(1);
        default: write_fraction($urandom_range(0, 256));
      endcase
      while (items_sent < PHASE_ITEMS * (ph + 1) + plan.size()) begin
        tx_steady = ($urandom_range(0, 9) == 0);
        random_read(PHASE_ITEMS * (ph + 1) + plan.size() - items_sent);
      end
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
